// ----- design/scr_pkg.sv -----
// shared constants and arithmetic helpers for the stereo reverb
`timescale 1ns / 1ps
package scr_pkg;

  // sample and internal word formats
  localparam int SB        = 16;              // Q1.15 sample
  localparam int IW        = 24;              // Q4.20 internal
  localparam int ACC_W     = IW + 4;          // headroom for sums before saturation
  localparam int CW        = 16;              // Q0.16 coefficient
  localparam int TO_INT_SH = (IW - 4) - (SB - 1);

  localparam logic [CW-1:0] Q16_COMB_FB = 16'd55050;
  localparam logic [CW-1:0] Q16_DAMP    = 16'd13107;
  localparam logic [CW-1:0] Q16_UNDAMP  = 16'd52429;
  localparam logic [CW-1:0] Q16_AP_FB   = 16'd32768;
  localparam logic [CW-1:0] Q16_GAIN    = 16'd983;

  // line length scaling
  localparam int RATE_W = 17;
  localparam int TUN_W  = 11;
  localparam int DIV_W  = RATE_W + TUN_W;
  // x / 44100 as floor((x >> 2) * ceil(2^40 / 11025) / 2^40), exact below 2^28
  localparam int RECIP_W  = 27;
  localparam int RECIP_SH = 40;
  localparam logic [RECIP_W-1:0] REF_RATE_RECIP = 27'd99728946;
  localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;
  localparam int SPREAD = 23;

  localparam logic [TUN_W-1:0] COMB_TUNING [8] = '{
    11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617
  };
  localparam logic [TUN_W-1:0] AP_TUNING [4] = '{11'd556, 11'd441, 11'd341, 11'd225};

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_INPUT = 2'd1;

  function automatic logic signed [IW-1:0] sat_int(input logic signed [ACC_W-1:0] v);
    if (&v[ACC_W-1:IW-1] || ~|v[ACC_W-1:IW-1]) begin
      return v[IW-1:0];
    end
    return v[ACC_W-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
  endfunction

  // round to sample precision, then clamp
  function automatic logic [SB-1:0] to_smp(input logic signed [IW-1:0] x);
    logic signed [IW:0]              s;
    logic signed [IW-TO_INT_SH:0]    r;
    s = $signed({x[IW-1], x}) + $signed((IW+1)'(1 << (TO_INT_SH - 1)));
    r = s[IW:TO_INT_SH];
    if (&r[IW-TO_INT_SH:SB-1] || ~|r[IW-TO_INT_SH:SB-1]) begin
      return r[SB-1:0];
    end
    return r[IW-TO_INT_SH] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
  endfunction

endpackage

// ----- design/scr_ifs.sv -----
// valid/ready channel interfaces for frames and configuration writes
`timescale 1ns / 1ps
interface scr_frame_in_if;
  import scr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [SB-1:0] left_in;
  logic signed [SB-1:0] right_in;
  logic                 frame_last;
  modport source (output valid, left_in, right_in, frame_last, input ready);
  modport sink   (input valid, left_in, right_in, frame_last, output ready);
endinterface

interface scr_frame_out_if;
  import scr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [SB-1:0] left_out;
  logic signed [SB-1:0] right_out;
  logic                 frame_last_out;
  modport source (output valid, left_out, right_out, frame_last_out, input ready);
  modport sink   (input valid, left_out, right_out, frame_last_out, output ready);
endinterface

interface scr_cfg_if;
  import scr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RATE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/scr_mulq.sv -----
// shared coefficient multiplier with rounding, result registered
`timescale 1ns / 1ps
module scr_mulq (
  input  logic                          clk_i,
  input  logic signed [scr_pkg::IW-1:0] x_i,
  input  logic [scr_pkg::CW-1:0]        c_i,
  output logic signed [scr_pkg::IW-1:0] p_o
);
  import scr_pkg::*;

  logic signed [IW+CW:0] prod;
  logic signed [IW-1:0]  p_q;

  // floor((x*c + 0.5 lsb) / 2^16), always fits the internal width
  assign prod = x_i * $signed({1'b0, c_i}) + $signed((IW+CW+1)'(1 << (CW - 1)));

  always_ff @(posedge clk_i) begin
    p_q <= prod[CW+IW-1:CW];
  end

  assign p_o = p_q;
endmodule

// ----- design/scr_div.sv -----
// division by the reference rate through a reciprocal multiply, with the operand and the quotient registered
`timescale 1ns / 1ps
module scr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [scr_pkg::DIV_W-1:0]  dividend_i,
  output logic                       done_o,
  output logic [scr_pkg::DIV_W-1:0]  quo_o
);
  import scr_pkg::*;

  localparam int N_W    = DIV_W - 2;
  localparam int PROD_W = N_W + RECIP_W;

  logic [N_W-1:0]    n_q;
  logic              pend_q;
  logic              done_q;
  logic [DIV_W-1:0]  quo_q;
  logic [PROD_W-1:0] prod;

  // the two low bits drop out since 44100 = 4 * 11025
  assign prod = PROD_W'(n_q) * PROD_W'(REF_RATE_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pend_q <= start_i;
      done_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= dividend_i[DIV_W-1:2];
    end
    if (pend_q) begin
      quo_q <= DIV_W'(prod[PROD_W-1:RECIP_SH]);
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ----- design/stereo_comb_allpass_reverb.sv -----
// stereo reverb top level: sequencer, delay memories and filter state
`timescale 1ns / 1ps
// Stereo reverb with a fixed room: each frame is mixed to mono, run through
// 2*NUM_COMBS damped feedback combs (left bank, then right bank) and then
// through NUM_ALLPASSES series allpasses per channel. All filter updates go
// through one shared coefficient multiplier under a sequencer, one frame at a
// time: a frame runs six multiplier/memory steps per comb and three per
// allpass from accept to result, and the next frame is taken only after the
// result has been loaded into the output register. Input ready is low during
// that time; a finished result waits in the output register while the next
// frame is taken. After reset and after every sample_rate write the block
// runs a clearing pass over both delay memories, then computes the line
// lengths with a reciprocal multiply, one tuning after another
// (NUM_COMBS + NUM_ALLPASSES tunings). Configuration writes are always taken;
// stereo_input 0 feeds the left sample to both channels.
module stereo_comb_allpass_reverb #(
  parameter int NUM_COMBS         = 8,
  parameter int NUM_ALLPASSES     = 4,
  parameter int MAX_COMB_DELAY    = 4096,
  parameter int MAX_ALLPASS_DELAY = 2048
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  scr_frame_in_if.sink    frame_in,
  scr_frame_out_if.source frame_out,
  scr_cfg_if.sink         cfg
);
  import scr_pkg::*;

  localparam int NC2       = 2 * NUM_COMBS;
  localparam int NA2       = 2 * NUM_ALLPASSES;
  localparam int KC_W      = $clog2(NC2);
  localparam int KA_W      = $clog2(NA2);
  localparam int LJ_W      = $clog2(NUM_COMBS + NUM_ALLPASSES);
  localparam int CP_W      = $clog2(MAX_COMB_DELAY);
  localparam int CL_W      = $clog2(MAX_COMB_DELAY + 1);
  localparam int AP_W      = $clog2(MAX_ALLPASS_DELAY);
  localparam int AL_W      = $clog2(MAX_ALLPASS_DELAY + 1);
  localparam int CM_DEPTH  = NC2 * MAX_COMB_DELAY;
  localparam int AM_DEPTH  = NA2 * MAX_ALLPASS_DELAY;
  localparam int CM_AW     = $clog2(CM_DEPTH);
  localparam int AM_AW     = $clog2(AM_DEPTH);
  localparam int CLR_DEPTH = (CM_DEPTH > AM_DEPTH) ? CM_DEPTH : AM_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  typedef enum logic [17:0] {
    S_CLR  = 18'h00001,
    S_LMUL = 18'h00002,
    S_LDIV = 18'h00004,
    S_IDLE = 18'h00008,
    S_MONO = 18'h00010,
    S_MIX  = 18'h00020,
    S_C0   = 18'h00040,
    S_C1   = 18'h00080,
    S_C2   = 18'h00100,
    S_C3   = 18'h00200,
    S_C4   = 18'h00400,
    S_C5   = 18'h00800,
    S_ASAT = 18'h01000,
    S_A0   = 18'h02000,
    S_A1   = 18'h04000,
    S_A2   = 18'h08000,
    S_OUT  = 18'h10000,
    S_SPARE = 18'h20000
  } state_e;

  state_e state_q, state_d;

  // control state
  logic [CLR_W-1:0]    clr_cnt_q;
  logic [LJ_W-1:0]     li_q;
  logic [KC_W-1:0]     ci_q;
  logic [KA_W-1:0]     ai_q;
  logic [CP_W-1:0]     cpos_q [NC2];
  logic [AP_W-1:0]     apos_q [NA2];
  logic signed [IW-1:0] clp_q [NC2];
  logic [RATE_W-1:0]   rate_q;
  logic                stereo_q;
  logic                out_valid_q;

  // payload
  logic signed [SB-1:0]    l_q, r_q;
  logic                    last_q;
  logic signed [IW-1:0]    mono_q;
  logic signed [ACC_W-1:0] acc_q [2];
  logic signed [IW-1:0]    chan_q [2];
  logic signed [IW-1:0]    t_q, u_q;
  logic [CL_W-1:0]         clen_q [NC2];
  logic [AL_W-1:0]         alen_q [NA2];
  logic signed [SB-1:0]    lout_q, rout_q;
  logic                    lastout_q;

  // delay memories
  logic signed [IW-1:0] cm_mem [CM_DEPTH];
  logic signed [IW-1:0] am_mem [AM_DEPTH];
  logic signed [IW-1:0] cm_rd_q, am_rd_q;
  logic                 cm_we, am_we;
  logic [CM_AW-1:0]     caddr, cm_waddr;
  logic [AM_AW-1:0]     aaddr, am_waddr;
  logic signed [IW-1:0] cm_wdata, am_wdata;

  // shared units
  logic signed [IW-1:0] mul_x, mul_p;
  logic [CW-1:0]        mul_c;
  logic                 div_start, div_done;
  logic [DIV_W-1:0]     div_dvd, div_quo;

  logic                 in_acc, out_load, rate_wr, cfg_wr;
  logic                 cch, ach;
  logic signed [SB:0]   dry_sum;
  logic signed [IW-1:0] mono_in;
  logic [CL_W-1:0]      cpos_nxt;
  logic [AL_W-1:0]      apos_nxt;
  logic [TUN_W-1:0]     tuning;
  logic                 li_comb;
  logic [DIV_W:0]       q_sp;
  logic [CL_W-1:0]      cl_left, cl_right;
  logic [AL_W-1:0]      al_left, al_right;
  logic [KC_W-1:0]      cl_idx;
  logic [KA_W-1:0]      al_idx;

  assign cfg_wr   = cfg.valid && cfg.ready;
  assign rate_wr  = cfg_wr && (cfg.index == CFG_SAMPLE_RATE);
  assign in_acc   = frame_in.valid && frame_in.ready;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || frame_out.ready);

  assign cfg.ready      = 1'b1;
  assign frame_in.ready = (state_q == S_IDLE);

  // channel of the current comb / allpass
  assign cch = ({1'b0, ci_q} >= (KC_W+1)'(NUM_COMBS));
  assign ach = ({1'b0, ai_q} >= (KA_W+1)'(NUM_ALLPASSES));

  assign dry_sum = (SB+1)'(l_q) + (SB+1)'(r_q);
  assign mono_in = IW'(dry_sum) <<< TO_INT_SH;

  // line addresses and next positions
  assign caddr    = CM_AW'(ci_q) * CM_AW'(MAX_COMB_DELAY) + CM_AW'(cpos_q[ci_q]);
  assign aaddr    = AM_AW'(ai_q) * AM_AW'(MAX_ALLPASS_DELAY) + AM_AW'(apos_q[ai_q]);
  assign cpos_nxt = CL_W'(cpos_q[ci_q]) + CL_W'(1);
  assign apos_nxt = AL_W'(apos_q[ai_q]) + AL_W'(1);

  // length setup: scaled tuning, then minimum of one and caps
  assign li_comb = ({1'b0, li_q} < (LJ_W+1)'(NUM_COMBS));
  assign tuning  = li_comb ? COMB_TUNING[3'(li_q)]
                           : AP_TUNING[2'(li_q - LJ_W'(NUM_COMBS))];
  assign div_start = (state_q == S_LMUL);
  assign div_dvd   = DIV_W'(tuning) * DIV_W'(rate_q);
  assign q_sp      = (DIV_W+1)'(div_quo) + (DIV_W+1)'(SPREAD);

  assign cl_left  = (div_quo == '0) ? CL_W'(1) :
                    (div_quo > DIV_W'(MAX_COMB_DELAY)) ? CL_W'(MAX_COMB_DELAY) : CL_W'(div_quo);
  assign cl_right = (q_sp > (DIV_W+1)'(MAX_COMB_DELAY)) ? CL_W'(MAX_COMB_DELAY) : CL_W'(q_sp);
  assign al_left  = (div_quo == '0) ? AL_W'(1) :
                    (div_quo > DIV_W'(MAX_ALLPASS_DELAY)) ? AL_W'(MAX_ALLPASS_DELAY)
                                                          : AL_W'(div_quo);
  assign al_right = (q_sp > (DIV_W+1)'(MAX_ALLPASS_DELAY)) ? AL_W'(MAX_ALLPASS_DELAY)
                                                           : AL_W'(q_sp);
  assign cl_idx = KC_W'(li_q);
  assign al_idx = KA_W'(li_q - LJ_W'(NUM_COMBS));

  scr_mulq u_mulq (
    .clk_i (clk_i),
    .x_i   (mul_x),
    .c_i   (mul_c),
    .p_o   (mul_p)
  );

  scr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // multiplier operand select per sequencer step
  always_comb begin
    mul_x = '0;
    mul_c = '0;
    case (state_q)
      S_MONO: begin
        mul_x = mono_in;
        mul_c = Q16_GAIN;
      end
      S_C1: begin
        mul_x = cm_rd_q;
        mul_c = Q16_UNDAMP;
      end
      S_C2: begin
        mul_x = clp_q[ci_q];
        mul_c = Q16_DAMP;
      end
      S_C4: begin
        mul_x = clp_q[ci_q];
        mul_c = Q16_COMB_FB;
      end
      S_A1: begin
        mul_x = am_rd_q;
        mul_c = Q16_AP_FB;
      end
      default: begin
        mul_x = '0;
        mul_c = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1)) state_d = S_LMUL;
      S_LMUL: state_d = S_LDIV;
      S_LDIV: begin
        if (div_done) begin
          state_d = (li_q == LJ_W'(NUM_COMBS + NUM_ALLPASSES - 1)) ? S_IDLE : S_LMUL;
        end
      end
      S_IDLE: if (frame_in.valid) state_d = S_MONO;
      S_MONO: state_d = S_MIX;
      S_MIX:  state_d = S_C0;
      S_C0:   state_d = S_C1;
      S_C1:   state_d = S_C2;
      S_C2:   state_d = S_C3;
      S_C3:   state_d = S_C4;
      S_C4:   state_d = S_C5;
      S_C5:   state_d = (ci_q == KC_W'(NC2 - 1)) ? S_ASAT : S_C0;
      S_ASAT: state_d = S_A0;
      S_A0:   state_d = S_A1;
      S_A1:   state_d = S_A2;
      S_A2:   state_d = (ai_q == KA_W'(NA2 - 1)) ? S_OUT : S_A0;
      S_OUT:  if (!out_valid_q || frame_out.ready) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
    // a new rate restarts the clearing pass and length setup
    if (rate_wr) state_d = S_CLR;
  end

  // memory write ports: clearing sweep or filter write-back
  assign cm_we    = ((state_q == S_CLR) && ({1'b0, clr_cnt_q} < (CLR_W+1)'(CM_DEPTH)))
                    || (state_q == S_C5);
  assign am_we    = ((state_q == S_CLR) && ({1'b0, clr_cnt_q} < (CLR_W+1)'(AM_DEPTH)))
                    || (state_q == S_A2);
  assign cm_waddr = (state_q == S_CLR) ? CM_AW'(clr_cnt_q) : caddr;
  assign am_waddr = (state_q == S_CLR) ? AM_AW'(clr_cnt_q) : aaddr;
  assign cm_wdata = (state_q == S_CLR) ? '0 : sat_int(ACC_W'(mono_q) + ACC_W'(mul_p));
  assign am_wdata = (state_q == S_CLR) ? '0 : sat_int(ACC_W'(chan_q[ach]) + ACC_W'(mul_p));

  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      cm_mem[cm_waddr] <= cm_wdata;
    end
    cm_rd_q <= cm_mem[caddr];
  end

  always_ff @(posedge clk_i) begin
    if (am_we) begin
      am_mem[am_waddr] <= am_wdata;
    end
    am_rd_q <= am_mem[aaddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      li_q        <= '0;
      ci_q        <= '0;
      ai_q        <= '0;
      rate_q      <= RATE_RESET;
      stereo_q    <= 1'b1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NC2; i++) begin
        cpos_q[i] <= '0;
        clp_q[i]  <= '0;
      end
      for (int i = 0; i < NA2; i++) begin
        apos_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (frame_out.ready) out_valid_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;

      case (state_q)
        S_CLR:  clr_cnt_q <= clr_cnt_q + CLR_W'(1);
        S_LDIV: if (div_done) li_q <= li_q + LJ_W'(1);
        S_MIX:  ci_q <= '0;
        S_C3:   clp_q[ci_q] <= sat_int(ACC_W'(t_q) + ACC_W'(mul_p));
        S_C5: begin
          cpos_q[ci_q] <= (cpos_nxt >= clen_q[ci_q]) ? '0 : CP_W'(cpos_nxt);
          ci_q         <= ci_q + KC_W'(1);
        end
        S_ASAT: ai_q <= '0;
        S_A2: begin
          apos_q[ai_q] <= (apos_nxt >= alen_q[ai_q]) ? '0 : AP_W'(apos_nxt);
          ai_q         <= ai_q + KA_W'(1);
        end
        default: ;
      endcase

      if (cfg_wr && (cfg.index == CFG_STEREO_INPUT)) stereo_q <= cfg.data[0];
      if (rate_wr) begin
        rate_q    <= cfg.data;
        clr_cnt_q <= '0;
        li_q      <= '0;
        for (int i = 0; i < NC2; i++) begin
          cpos_q[i] <= '0;
          clp_q[i]  <= '0;
        end
        for (int i = 0; i < NA2; i++) begin
          apos_q[i] <= '0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      l_q    <= frame_in.left_in;
      r_q    <= stereo_q ? frame_in.right_in : frame_in.left_in;
      last_q <= frame_in.frame_last;
    end
    case (state_q)
      S_LDIV: begin
        if (div_done) begin
          if (li_comb) begin
            clen_q[cl_idx]                        <= cl_left;
            clen_q[cl_idx + KC_W'(NUM_COMBS)]     <= cl_right;
          end else begin
            alen_q[al_idx]                        <= al_left;
            alen_q[al_idx + KA_W'(NUM_ALLPASSES)] <= al_right;
          end
        end
      end
      S_MIX: begin
        mono_q   <= mul_p;
        acc_q[0] <= '0;
        acc_q[1] <= '0;
      end
      S_C1:   acc_q[cch] <= acc_q[cch] + ACC_W'(cm_rd_q);
      S_C2:   t_q <= mul_p;
      S_ASAT: begin
        chan_q[0] <= sat_int(acc_q[0]);
        chan_q[1] <= sat_int(acc_q[1]);
      end
      S_A1:   u_q <= sat_int(ACC_W'(am_rd_q) - ACC_W'(chan_q[ach]));
      S_A2:   chan_q[ach] <= u_q;
      default: ;
    endcase
    if (out_load) begin
      lout_q    <= $signed(to_smp(chan_q[0]));
      rout_q    <= $signed(to_smp(chan_q[1]));
      lastout_q <= last_q;
    end
  end

  assign frame_out.valid          = out_valid_q;
  assign frame_out.left_out       = lout_q;
  assign frame_out.right_out      = rout_q;
  assign frame_out.frame_last_out = lastout_q;
endmodule

// ----- design/scr_checker.sv -----
// port-level checks for the stereo reverb, bound to the top level
`timescale 1ns / 1ps
module scr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [scr_pkg::SB-1:0]        out_left_i,
  input logic [scr_pkg::SB-1:0]        out_right_i,
  input logic                          out_last_i,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_i,
  input logic [scr_pkg::CFG_IDX_W-1:0] cfg_index_i
);
  import scr_pkg::*;

  // one frame at a time: no accept right after an accept
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a frame is in flight");

  // a new rate starts the clearing pass
  a_rate_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i && (cfg_index_i == CFG_SAMPLE_RATE) |=> !in_ready_i)
    else $error("input ready during clearing pass");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_left_i) && $stable(out_right_i) && $stable(out_last_i))
    else $error("result changed while stalled");
endmodule

bind stereo_comb_allpass_reverb scr_checker u_scr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (frame_in.valid),
  .in_ready_i  (frame_in.ready),
  .out_valid_i (frame_out.valid),
  .out_ready_i (frame_out.ready),
  .out_left_i  (frame_out.left_out),
  .out_right_i (frame_out.right_out),
  .out_last_i  (frame_out.frame_last_out),
  .cfg_valid_i (cfg.valid),
  .cfg_ready_i (cfg.ready),
  .cfg_index_i (cfg.index)
);

// ----- bench/testbench.sv -----
// self-checking testbench for the stereo comb/allpass reverb
`timescale 1ns / 1ps
module testbench;
  import scr_pkg::*;

  localparam int N_COMB  = 8;
  localparam int N_AP    = 4;
  localparam int COMB_SZ = 4096;
  localparam int AP_SZ   = 2048;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 last;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  scr_frame_in_if  frame_in ();
  scr_frame_out_if frame_out ();
  scr_cfg_if       cfg ();

  stereo_comb_allpass_reverb DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_in (frame_in.sink),
    .frame_out(frame_out.source),
    .cfg      (cfg.sink)
  );

  // reverb state mirror, kept in step with accepted transactions
  int unsigned rate_hz;
  bit          stereo_mode;
  int          comb_mem [2*N_COMB][COMB_SZ];
  int          comb_pos [2*N_COMB];
  int          comb_lp  [2*N_COMB];
  int          ap_mem   [2*N_AP][AP_SZ];
  int          ap_pos   [2*N_AP];
  int          comb_len [2*N_COMB];
  int          ap_len   [2*N_AP];

  frame_t pending_frames [$];
  frame_t wet_expected [$];
  int     errors = 0;
  int     frames_sent = 0;
  int     frames_checked = 0;
  int     rate_writes = 0;

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // coefficient product with round-half-up, floor shift
  function automatic longint qmul(longint x, longint c);
    return (x * c + 32768) >>> 16;
  endfunction

  function automatic int fit_len(longint v, int cap);
    if (v < 1) return 1;
    if (v > cap) return cap;
    return int'(v);
  endfunction

  // new rate: rescale all line lengths and wipe every filter
  function automatic void retune();
    int     tc [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
    int     ta [4] = '{556, 441, 341, 225};
    longint base;
    for (int i = 0; i < N_COMB; i++) begin
      base = longint'(tc[i]) * rate_hz / 44100;
      comb_len[i] = fit_len(base, COMB_SZ);
      comb_len[N_COMB+i] = fit_len(base + 23, COMB_SZ);
    end
    for (int i = 0; i < N_AP; i++) begin
      base = longint'(ta[i]) * rate_hz / 44100;
      ap_len[i] = fit_len(base, AP_SZ);
      ap_len[N_AP+i] = fit_len(base + 23, AP_SZ);
    end
    for (int c = 0; c < 2*N_COMB; c++) begin
      comb_pos[c] = 0;
      comb_lp[c] = 0;
      for (int k = 0; k < COMB_SZ; k++) comb_mem[c][k] = 0;
    end
    for (int a = 0; a < 2*N_AP; a++) begin
      ap_pos[a] = 0;
      for (int k = 0; k < AP_SZ; k++) ap_mem[a][k] = 0;
    end
  endfunction

  function automatic longint comb_update(int c, longint mono);
    longint o, lp;
    o = comb_mem[c][comb_pos[c]];
    lp = clamp(qmul(o, Q16_UNDAMP) + qmul(comb_lp[c], Q16_DAMP), IW);
    comb_lp[c] = int'(lp);
    comb_mem[c][comb_pos[c]] = int'(clamp(mono + qmul(lp, Q16_COMB_FB), IW));
    comb_pos[c] = (comb_pos[c] + 1 >= comb_len[c]) ? 0 : comb_pos[c] + 1;
    return o;
  endfunction

  function automatic longint allpass_update(int a, longint x);
    longint b, y;
    b = ap_mem[a][ap_pos[a]];
    y = clamp(b - x, IW);
    ap_mem[a][ap_pos[a]] = int'(clamp(x + qmul(b, Q16_AP_FB), IW));
    ap_pos[a] = (ap_pos[a] + 1 >= ap_len[a]) ? 0 : ap_pos[a] + 1;
    return y;
  endfunction

  function automatic logic [SB-1:0] wet_sample(longint x);
    return SB'(clamp((x + 16) >>> 5, SB));
  endfunction

  function automatic frame_t reverb_frame(frame_t dry);
    longint l, r, mono, accl, accr;
    frame_t wet;
    l = longint'(dry.left);
    r = stereo_mode ? longint'(dry.right) : l;
    mono = clamp(qmul((l <<< 5) + (r <<< 5), Q16_GAIN), IW);
    accl = 0;
    accr = 0;
    for (int i = 0; i < N_COMB; i++) begin
      accl += comb_update(i, mono);
      accr += comb_update(N_COMB + i, mono);
    end
    accl = clamp(accl, IW);
    accr = clamp(accr, IW);
    for (int i = 0; i < N_AP; i++) begin
      accl = allpass_update(i, accl);
      accr = allpass_update(N_AP + i, accr);
    end
    wet.left = wet_sample(accl);
    wet.right = wet_sample(accr);
    wet.last = dry.last;
    return wet;
  endfunction

  // no idling on either side over a long middle stretch
  function automatic bit take_gap();
    if (frames_sent >= 500 && frames_sent < 800) return 1'b0;
    return $urandom_range(99) < 20;
  endfunction

  // frame driver: next transaction once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni && (!frame_in.valid || frame_in.ready)) begin
      if (pending_frames.size() > 0 && !take_gap()) begin
        frame_t f;
        f = pending_frames.pop_front();
        frame_in.valid <= 1'b1;
        frame_in.left_in <= f.left;
        frame_in.right_in <= f.right;
        frame_in.frame_last <= f.last;
      end else begin
        frame_in.valid <= 1'b0;
      end
    end
  end

  // accepted frames and config writes update the mirror
  always @(posedge clk_i) begin
    if (rst_ni && frame_in.valid && frame_in.ready) begin
      frame_t dry;
      dry.left = frame_in.left_in;
      dry.right = frame_in.right_in;
      dry.last = frame_in.frame_last;
      wet_expected.push_back(reverb_frame(dry));
      frames_sent++;
    end
    if (rst_ni && cfg.valid && cfg.ready) begin
      if (cfg.index == CFG_SAMPLE_RATE) begin
        rate_hz = cfg.data;
        retune();
        rate_writes++;
      end else if (cfg.index == CFG_STEREO_INPUT) begin
        stereo_mode = cfg.data[0];
      end
    end
  end

  // result sink with random backpressure, compares against oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && frame_out.valid && frame_out.ready) begin
      if (wet_expected.size() == 0) begin
        $display("%0t: unexpected result L=%0d R=%0d", $time,
                 frame_out.left_out, frame_out.right_out);
        errors++;
      end else begin
        frame_t e;
        e = wet_expected.pop_front();
        if (e.left !== frame_out.left_out) begin
          $display("%0t: left_out expected %0d got %0d", $time, e.left, frame_out.left_out);
          errors++;
        end
        if (e.right !== frame_out.right_out) begin
          $display("%0t: right_out expected %0d got %0d", $time, e.right,
                   frame_out.right_out);
          errors++;
        end
        if (e.last !== frame_out.frame_last_out) begin
          $display("%0t: frame_last_out expected %0b got %0b", $time, e.last,
                   frame_out.frame_last_out);
          errors++;
        end
      end
      frames_checked++;
    end
    if (rst_ni) frame_out.ready <= !take_gap();
  end

  // settle, then look again so a frame taken at the same edge is not missed
  task automatic wait_drained();
    do begin
      while (pending_frames.size() > 0 || frame_in.valid || wet_expected.size() > 0)
        @(posedge clk_i);
      repeat (150) @(posedge clk_i);
    end while (pending_frames.size() > 0 || frame_in.valid || wet_expected.size() > 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic queue_frame(int l, int r, bit last);
    frame_t f;
    f.left = SB'(l);
    f.right = SB'(r);
    f.last = last;
    pending_frames.push_back(f);
  endtask

  // random frames: half music-like levels, the rest full-range random, full scale or silence
  task automatic queue_random(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(9);
      if (pick < 5)
        queue_frame($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                    $urandom_range(7) == 0);
      else if (pick < 8)
        queue_frame($urandom, $urandom, $urandom_range(1));
      else if (pick == 8)
        queue_frame(0, 0, $urandom_range(1));
      else
        queue_frame($urandom_range(1) ? 32767 : -32768,
                    $urandom_range(1) ? 32767 : -32768, 1'b0);
    end
  endtask

  initial begin
    frame_in.valid = 1'b0;
    frame_in.left_in = '0;
    frame_in.right_in = '0;
    frame_in.frame_last = 1'b0;
    frame_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    rate_hz = 44100;
    stereo_mode = 1'b1;
    retune();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, silence, impulse, frame_last both ways
    queue_frame(32767, 32767, 1'b0);
    queue_frame(-32768, -32768, 1'b1);
    queue_frame(32767, -32768, 1'b0);
    queue_frame(-32768, 32767, 1'b1);
    queue_frame(0, 0, 1'b0);
    queue_frame(1, -1, 1'b0);
    queue_frame(-1, 1, 1'b1);
    for (int i = 0; i < 8; i++) queue_frame(32767, 32767, 1'b0);
    for (int i = 0; i < 6; i++) queue_frame(0, 0, i == 5);
    queue_random(400);

    // mono input at rate 8000
    wait_drained();
    write_reg(CFG_STEREO_INPUT, 1'b0);
    write_reg(CFG_SAMPLE_RATE, 17'd8000);
    queue_frame(32767, -32768, 1'b0);
    queue_frame(-32768, 32767, 1'b1);
    queue_random(300);

    // a high rate (96000), stereo again
    wait_drained();
    write_reg(CFG_SAMPLE_RATE, 17'd96000);
    write_reg(CFG_STEREO_INPUT, 1'b1);
    queue_random(300);

    // zero rate gives minimum lengths; unknown indexes are ignored
    wait_drained();
    write_reg(CFG_SAMPLE_RATE, 17'd0);
    write_reg(2'd2, 17'h1FFFF);
    write_reg(2'd3, 17'd0);
    queue_random(150);

    // largest rate hits the comb length cap, mono
    wait_drained();
    write_reg(CFG_SAMPLE_RATE, 17'h1FFFF);
    write_reg(CFG_STEREO_INPUT, 1'b0);
    queue_random(250);

    // back to reset settings
    wait_drained();
    write_reg(CFG_SAMPLE_RATE, 17'd44100);
    write_reg(CFG_STEREO_INPUT, 1'b1);
    queue_random(250);

    wait_drained();
    $display("covered %0d frames over %0d rate settings, mono and stereo, with backpressure",
             frames_checked, rate_writes + 1);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", wet_expected.size());
    $display("testbench failed");
    $finish;
  end

endmodule
